>>> sv/first_fit_heap_allocator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the first-fit heap allocator
// Each macro expects the clock aclk and the active-low reset aresetn in scope.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define FFHA_ASSERT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ffha assertion failed");
`define FFHA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ffha assertion failed");
`else
`define FFHA_ASSERT(lbl, ante, cons)
`define FFHA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> sv/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and constants of the first-fit heap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffha_pkg;

    localparam int HEAP_UNITS_DEF = 4096;
    localparam int HDR_UNITS_DEF  = 1;
    localparam int LIMIT_RESET    = 4096;

    localparam int CFG_W    = 13;
    localparam int SIZE_W   = 12;
    localparam int OFFSET_W = 12;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_SIZE = 2'd1,
        ST_NO_MEM   = 2'd2,
        ST_BAD_FREE = 2'd3
    } status_t;

    // Command to the header memory: read and write enables.
    typedef struct packed {
        logic rd;
        logic wr;
    } mem_cmd_t;

endpackage

`default_nettype wire

>>> sv/ffha_hdr_mem.sv
// ----------------------------------------------------------------------------
// ffha_hdr_mem
// Header store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_hdr_mem #(
    parameter int DEPTH = ffha_pkg::HEAP_UNITS_DEF,
    parameter int AW    = 12,
    parameter int HW    = 26
) (
    input  wire logic              aclk,
    input  wire ffha_pkg::mem_cmd_t cmd,
    input  wire logic [AW-1:0]     rd_addr,
    input  wire logic [AW-1:0]     wr_addr,
    input  wire logic [HW-1:0]     wr_data,
    output logic      [HW-1:0]     rd_data
);

    logic [HW-1:0] mem [DEPTH];
    logic [HW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (cmd.wr) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> sv/ffha_ctrl.sv
// ----------------------------------------------------------------------------
// ffha_ctrl
// Sequencer: walks, splits and merges block headers in the header store.
// ----------------------------------------------------------------------------
`default_nettype none

`include "first_fit_heap_allocator_assert.svh"

module ffha_ctrl #(
    parameter int HEAP_UNITS = ffha_pkg::HEAP_UNITS_DEF,
    parameter int HDR_UNITS  = ffha_pkg::HDR_UNITS_DEF,
    parameter int AW         = 12,
    parameter int HW         = 26
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wen,
    input  wire logic [ffha_pkg::CFG_W-1:0]      cfg_wdata,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_action,
    input  wire logic [ffha_pkg::SIZE_W-1:0]     s_req_size,
    input  wire logic [ffha_pkg::OFFSET_W-1:0]   s_free_offset,
    output logic                                 res_valid,
    input  wire logic                            res_ready,
    output logic [ffha_pkg::OFFSET_W-1:0]        res_offset,
    output ffha_pkg::status_t                    res_status,
    output ffha_pkg::mem_cmd_t                   mem_cmd,
    output logic [AW-1:0]                        mem_rd_addr,
    output logic [AW-1:0]                        mem_wr_addr,
    output logic [HW-1:0]                        mem_wr_data,
    input  wire logic [HW-1:0]                   mem_rd_data
);

    localparam int LW = AW + 1;
    localparam int SW = AW + 2;
    localparam int MW = (SW > ffha_pkg::CFG_W) ? SW : ffha_pkg::CFG_W;
    localparam int LIM_RST = (ffha_pkg::LIMIT_RESET > HEAP_UNITS) ?
                             HEAP_UNITS : ffha_pkg::LIMIT_RESET;
    localparam logic [MW-1:0] HDR_M  = MW'(HDR_UNITS);
    localparam logic [MW-1:0] LIM_LO = MW'(HDR_UNITS + 1);
    localparam logic [MW-1:0] LIM_HI = MW'(HEAP_UNITS);
    localparam logic [AW-1:0] LAST   = AW'(HEAP_UNITS - 1);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_A_CHK, S_A_AFT, S_A_WHEAD,
        S_F_BLK, S_F_PRV, S_F_NRD, S_F_NCHK, S_F_WCUR, S_RESP
    } state_t;

    state_t                         state_reg, state_next;
    logic [LW-1:0]                  limit_reg, limit_next;
    logic [AW-1:0]                  clr_cnt_reg, clr_cnt_next;
    logic [MW-1:0]                  head_reg, head_next;
    logic [MW-1:0]                  aux_reg, aux_next;
    logic [ffha_pkg::SIZE_W-1:0]    req_reg, req_next;
    logic [AW-1:0]                  cur_reg, cur_next;
    logic [AW-1:0]                  cur_size_reg, cur_size_next;
    logic [AW-1:0]                  cur_prev_reg, cur_prev_next;
    logic [AW-1:0]                  new_reg, new_next;
    logic                           link_only_reg, link_only_next;
    logic [ffha_pkg::OFFSET_W-1:0]  res_off_reg, res_off_next;
    ffha_pkg::status_t              res_status_reg, res_status_next;

    logic [AW-1:0] r_size, r_prev;
    logic          r_free, r_valid;
    logic [MW-1:0] lim_m, req_m, rsize_m, cfg_m, tmp_a, tmp_b;

    assign r_size  = mem_rd_data[AW-1:0];
    assign r_prev  = mem_rd_data[2*AW-1:AW];
    assign r_free  = mem_rd_data[2*AW];
    assign r_valid = mem_rd_data[2*AW+1];
    assign lim_m   = MW'(limit_reg);
    assign req_m   = MW'(req_reg);
    assign rsize_m = MW'(r_size);
    assign cfg_m   = MW'(cfg_wdata);

    always_comb begin
        state_next      = state_reg;
        limit_next      = limit_reg;
        clr_cnt_next    = clr_cnt_reg;
        head_next       = head_reg;
        aux_next        = aux_reg;
        req_next        = req_reg;
        cur_next        = cur_reg;
        cur_size_next   = cur_size_reg;
        cur_prev_next   = cur_prev_reg;
        new_next        = new_reg;
        link_only_next  = link_only_reg;
        res_off_next    = res_off_reg;
        res_status_next = res_status_reg;
        mem_cmd         = '0;
        mem_rd_addr     = '0;
        mem_wr_addr     = '0;
        mem_wr_data     = '0;
        s_ready         = 1'b0;
        tmp_a           = '0;
        tmp_b           = '0;

        unique case (state_reg)
            S_CLEAR: begin
                mem_cmd.wr  = 1'b1;
                mem_wr_addr = clr_cnt_reg;
                if (clr_cnt_reg == '0) begin
                    tmp_a       = lim_m - HDR_M;
                    mem_wr_data = {1'b1, 1'b1, {AW{1'b0}}, tmp_a[AW-1:0]};
                end
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    res_off_next   = '0;
                    link_only_next = 1'b0;
                    req_next       = s_req_size;
                    tmp_a          = MW'(s_free_offset);
                    tmp_b          = tmp_a - HDR_M;
                    if (s_action == ffha_pkg::ACT_ALLOC) begin
                        if (s_req_size == '0 || MW'(s_req_size) >= lim_m) begin
                            res_status_next = ffha_pkg::ST_BAD_SIZE;
                            state_next      = S_RESP;
                        end else begin
                            head_next  = '0;
                            mem_cmd.rd = 1'b1;
                            state_next = S_A_CHK;
                        end
                    end else if (s_free_offset == '0) begin
                        res_status_next = ffha_pkg::ST_OK;
                        state_next      = S_RESP;
                    end else if (tmp_a < HDR_M || tmp_b >= lim_m) begin
                        res_status_next = ffha_pkg::ST_BAD_FREE;
                        state_next      = S_RESP;
                    end else begin
                        cur_next    = tmp_b[AW-1:0];
                        mem_cmd.rd  = 1'b1;
                        mem_rd_addr = tmp_b[AW-1:0];
                        state_next  = S_F_BLK;
                    end
                end
            end
            S_A_CHK: begin
                tmp_a = head_reg + rsize_m + HDR_M;
                if (!r_valid) begin
                    res_status_next = ffha_pkg::ST_NO_MEM;
                    state_next      = S_RESP;
                end else if (rsize_m < req_m || !r_free) begin
                    head_next = tmp_a;
                    if (tmp_a >= lim_m) begin
                        res_status_next = ffha_pkg::ST_NO_MEM;
                        state_next      = S_RESP;
                    end else begin
                        mem_cmd.rd  = 1'b1;
                        mem_rd_addr = tmp_a[AW-1:0];
                    end
                end else begin
                    cur_next      = head_reg[AW-1:0];
                    cur_prev_next = r_prev;
                    cur_size_next = r_size;
                    state_next    = S_A_WHEAD;
                    if (rsize_m > req_m + HDR_M) begin
                        // Split: the remainder becomes a free block behind the payload.
                        tmp_b         = head_reg + HDR_M + req_m;
                        new_next      = tmp_b[AW-1:0];
                        cur_size_next = AW'(req_reg);
                        mem_cmd.wr    = 1'b1;
                        mem_wr_addr   = tmp_b[AW-1:0];
                        tmp_b         = rsize_m - req_m - HDR_M;
                        mem_wr_data   = {1'b1, 1'b1, head_reg[AW-1:0], tmp_b[AW-1:0]};
                        aux_next      = tmp_a;
                        if (tmp_a < lim_m) begin
                            mem_cmd.rd  = 1'b1;
                            mem_rd_addr = tmp_a[AW-1:0];
                            state_next  = S_A_AFT;
                        end
                    end
                end
            end
            S_A_AFT: begin
                if (r_valid) begin
                    mem_cmd.wr  = 1'b1;
                    mem_wr_addr = aux_reg[AW-1:0];
                    mem_wr_data = {1'b1, r_free, new_reg, r_size};
                end
                state_next = S_A_WHEAD;
            end
            S_A_WHEAD: begin
                mem_cmd.wr      = 1'b1;
                mem_wr_addr     = cur_reg;
                mem_wr_data     = {1'b1, 1'b0, cur_prev_reg, cur_size_reg};
                tmp_a           = MW'(cur_reg) + HDR_M;
                res_off_next    = tmp_a[ffha_pkg::OFFSET_W-1:0];
                res_status_next = ffha_pkg::ST_OK;
                state_next      = S_RESP;
            end
            S_F_BLK: begin
                if (!r_valid || r_free) begin
                    res_status_next = ffha_pkg::ST_BAD_FREE;
                    state_next      = S_RESP;
                end else begin
                    cur_size_next = r_size;
                    cur_prev_next = r_prev;
                    aux_next      = MW'(r_prev);
                    if (cur_reg != '0 && MW'(r_prev) < lim_m) begin
                        mem_cmd.rd  = 1'b1;
                        mem_rd_addr = r_prev;
                        state_next  = S_F_PRV;
                    end else begin
                        state_next = S_F_NRD;
                    end
                end
            end
            S_F_PRV: begin
                if (r_valid && r_free) begin
                    // Backward merge: the freed header disappears into its predecessor.
                    mem_cmd.wr    = 1'b1;
                    mem_wr_addr   = cur_reg;
                    tmp_a         = rsize_m + MW'(cur_size_reg) + HDR_M;
                    cur_next      = aux_reg[AW-1:0];
                    cur_size_next = tmp_a[AW-1:0];
                    cur_prev_next = r_prev;
                end
                state_next = S_F_NRD;
            end
            S_F_NRD: begin
                tmp_a    = MW'(cur_reg) + MW'(cur_size_reg) + HDR_M;
                aux_next = tmp_a;
                if (tmp_a < lim_m) begin
                    mem_cmd.rd  = 1'b1;
                    mem_rd_addr = tmp_a[AW-1:0];
                    state_next  = S_F_NCHK;
                end else begin
                    state_next = S_F_WCUR;
                end
            end
            S_F_NCHK: begin
                if (r_valid && r_free && !link_only_reg) begin
                    mem_cmd.wr     = 1'b1;
                    mem_wr_addr    = aux_reg[AW-1:0];
                    tmp_a          = MW'(cur_size_reg) + rsize_m + HDR_M;
                    cur_size_next  = tmp_a[AW-1:0];
                    link_only_next = 1'b1;
                    state_next     = S_F_NRD;
                end else begin
                    if (r_valid) begin
                        mem_cmd.wr  = 1'b1;
                        mem_wr_addr = aux_reg[AW-1:0];
                        mem_wr_data = {1'b1, r_free, cur_reg, r_size};
                    end
                    state_next = S_F_WCUR;
                end
            end
            S_F_WCUR: begin
                mem_cmd.wr      = 1'b1;
                mem_wr_addr     = cur_reg;
                mem_wr_data     = {1'b1, 1'b1, cur_prev_reg, cur_size_reg};
                res_status_next = ffha_pkg::ST_OK;
                state_next      = S_RESP;
            end
            S_RESP: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // A limit write restarts the initialisation sweep of the header store.
        if (cfg_wen) begin
            priority if (cfg_m < LIM_LO) begin
                limit_next = LIM_LO[LW-1:0];
            end else if (cfg_m > LIM_HI) begin
                limit_next = LIM_HI[LW-1:0];
            end else begin
                limit_next = cfg_m[LW-1:0];
            end
            clr_cnt_next = '0;
            state_next   = S_CLEAR;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            limit_reg     <= LW'(LIM_RST);
            clr_cnt_reg   <= '0;
            link_only_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            limit_reg     <= limit_next;
            clr_cnt_reg   <= clr_cnt_next;
            link_only_reg <= link_only_next;
        end
        head_reg       <= head_next;
        aux_reg        <= aux_next;
        req_reg        <= req_next;
        cur_reg        <= cur_next;
        cur_size_reg   <= cur_size_next;
        cur_prev_reg   <= cur_prev_next;
        new_reg        <= new_next;
        res_off_reg    <= res_off_next;
        res_status_reg <= res_status_next;
    end

    assign res_valid  = (state_reg == S_RESP);
    assign res_offset = res_off_reg;
    assign res_status = res_status_reg;

    `FFHA_ASSERT(a_no_rw_same_entry, mem_cmd.rd && mem_cmd.wr, mem_rd_addr != mem_wr_addr)
    `FFHA_ASSERT(a_walk_has_data, state_reg == S_A_CHK, $past(mem_cmd.rd))
    `FFHA_ASSERT(a_limit_range, 1'b1, MW'(limit_reg) >= LIM_LO && MW'(limit_reg) <= LIM_HI)
    `FFHA_ASSERT_NEXT(a_cfg_clears, cfg_wen, state_reg == S_CLEAR && !s_ready)

endmodule

`default_nettype wire

>>> sv/first_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator of heap units with splitting and coalescing of blocks.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ channel (valid/ready): s_action selects allocate
// or free, with s_req_size or s_free_offset. Each transaction yields exactly
// one result transaction on the m_ channel with m_payload_offset and m_status.
// One request is processed at a time. An allocate reads each block header
// visited on the walk, and the following block when a split has one inside
// the limit to relink. A free reads the freed header, its predecessor inside
// the limit and the next header. The single read port of the header memory
// is read once per visited header.
// A finished result sits in an output register, so the next request can be
// accepted while the receiver stalls; a second result waits inside the block.
// After reset, and after every write of the heap limit on cfg_wen/cfg_wdata,
// the header store is swept one entry per cycle, over all entries, to form
// one free block; s_ready stays low during the sweep.
// The limit is saturated to the range HDR_UNITS + 1 to HEAP_UNITS.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_heap_allocator #(
    parameter int HEAP_UNITS = ffha_pkg::HEAP_UNITS_DEF,
    parameter int HDR_UNITS  = ffha_pkg::HDR_UNITS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wen,
    input  wire logic [ffha_pkg::CFG_W-1:0]      cfg_wdata,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_action,
    input  wire logic [ffha_pkg::SIZE_W-1:0]     s_req_size,
    input  wire logic [ffha_pkg::OFFSET_W-1:0]   s_free_offset,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [ffha_pkg::OFFSET_W-1:0]        m_payload_offset,
    output logic [1:0]                           m_status
);

    localparam int AW = $clog2(HEAP_UNITS);
    localparam int HW = 2 * AW + 2;

    ffha_pkg::mem_cmd_t             mem_cmd;
    logic [AW-1:0]                  mem_rd_addr, mem_wr_addr;
    logic [HW-1:0]                  mem_wr_data, mem_rd_data;
    logic                           res_valid, res_ready;
    logic [ffha_pkg::OFFSET_W-1:0]  res_offset;
    ffha_pkg::status_t              res_status;

    logic                           m_valid_reg;
    logic [ffha_pkg::OFFSET_W-1:0]  m_offset_reg;
    logic [1:0]                     m_status_reg;

    ffha_ctrl #(
        .HEAP_UNITS (HEAP_UNITS),
        .HDR_UNITS  (HDR_UNITS),
        .AW         (AW),
        .HW         (HW)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_req_size    (s_req_size),
        .s_free_offset (s_free_offset),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res_offset    (res_offset),
        .res_status    (res_status),
        .mem_cmd       (mem_cmd),
        .mem_rd_addr   (mem_rd_addr),
        .mem_wr_addr   (mem_wr_addr),
        .mem_wr_data   (mem_wr_data),
        .mem_rd_data   (mem_rd_data)
    );

    ffha_hdr_mem #(
        .DEPTH (HEAP_UNITS),
        .AW    (AW),
        .HW    (HW)
    ) u_hdr_mem (
        .aclk    (aclk),
        .cmd     (mem_cmd),
        .rd_addr (mem_rd_addr),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_data (mem_rd_data)
    );

    // Output register: takes a new result whenever it is empty or being drained.
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
        if (res_ready && res_valid) begin
            m_offset_reg <= res_offset;
            m_status_reg <= res_status;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_payload_offset = m_offset_reg;
    assign m_status         = m_status_reg;

endmodule

`default_nettype wire

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the first-fit heap allocator. A predictor of
// the header store follows every accepted request, and each result is checked
// against the oldest predicted one. Directed requests come first, then random
// allocate and free traffic under several heap limits and idling patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    localparam int NUNITS     = ffha_pkg::HEAP_UNITS_DEF;
    localparam int NHDR       = ffha_pkg::HDR_UNITS_DEF;
    localparam int WATCH_MAX  = 30000;
    localparam int HOLD_LEN   = 400;

    typedef struct {
        logic [ffha_pkg::OFFSET_W-1:0] offset;
        ffha_pkg::status_t             status;
    } alloc_result_t;

    class heap_scoreboard;
        int unsigned   blk_size[NUNITS];
        int unsigned   blk_prev[NUNITS];
        bit            blk_free[NUNITS];
        bit            blk_valid[NUNITS];
        int unsigned   limit;
        int unsigned   live_offsets[$];
        alloc_result_t expected_results[$];
        int            errors;

        function new();
            errors = 0;
            set_limit(ffha_pkg::LIMIT_RESET);
        endfunction

        function void set_limit(int unsigned value);
            limit = value;
            if (limit < NHDR + 1) limit = NHDR + 1;
            if (limit > NUNITS) limit = NUNITS;
            for (int i = 0; i < NUNITS; i++) begin
                blk_size[i] = 0; blk_prev[i] = 0; blk_free[i] = 0; blk_valid[i] = 0;
            end
            blk_size[0] = limit - NHDR;
            blk_free[0] = 1;
            blk_valid[0] = 1;
            live_offsets.delete();
        endfunction

        function void clear_header(int unsigned at);
            blk_size[at] = 0; blk_prev[at] = 0; blk_free[at] = 0; blk_valid[at] = 0;
        endfunction

        function alloc_result_t allocate(int unsigned req);
            alloc_result_t r;
            int unsigned head, old_size, split_at, after;
            head = 0;
            r.offset = '0;
            r.status = ffha_pkg::ST_OK;
            if (req == 0 || req >= limit) begin
                r.status = ffha_pkg::ST_BAD_SIZE;
                return r;
            end
            while (head < limit && blk_valid[head] &&
                   (blk_size[head] < req || !blk_free[head]))
                head += blk_size[head] + NHDR;
            if (head >= limit || !blk_valid[head]) begin
                r.status = ffha_pkg::ST_NO_MEM;
                return r;
            end
            old_size = blk_size[head];
            if (old_size > req + NHDR) begin
                split_at = head + NHDR + req;
                blk_size[split_at] = old_size - req - NHDR;
                blk_free[split_at] = 1;
                blk_valid[split_at] = 1;
                blk_prev[split_at] = head;
                after = head + old_size + NHDR;
                if (after < limit && blk_valid[after]) blk_prev[after] = split_at;
                blk_size[head] = req;
            end
            blk_free[head] = 0;
            r.offset = ffha_pkg::OFFSET_W'(head + NHDR);
            live_offsets.push_back(head + NHDR);
            return r;
        endfunction

        function alloc_result_t release_block(int unsigned p);
            alloc_result_t r;
            int unsigned blk, prv, nxt;
            r.offset = '0;
            r.status = ffha_pkg::ST_OK;
            if (p == 0) return r;
            if (p < NHDR || p - NHDR >= limit) begin
                r.status = ffha_pkg::ST_BAD_FREE;
                return r;
            end
            blk = p - NHDR;
            if (!blk_valid[blk] || blk_free[blk]) begin
                r.status = ffha_pkg::ST_BAD_FREE;
                return r;
            end
            foreach (live_offsets[i])
                if (live_offsets[i] == p) begin
                    live_offsets.delete(i);
                    break;
                end
            blk_free[blk] = 1;
            if (blk != 0) begin
                prv = blk_prev[blk];
                if (prv < limit && blk_valid[prv] && blk_free[prv]) begin
                    blk_size[prv] += blk_size[blk] + NHDR;
                    clear_header(blk);
                    blk = prv;
                end
            end
            nxt = blk + blk_size[blk] + NHDR;
            if (nxt < limit && blk_valid[nxt] && blk_free[nxt]) begin
                blk_size[blk] += blk_size[nxt] + NHDR;
                clear_header(nxt);
                nxt = blk + blk_size[blk] + NHDR;
            end
            if (nxt < limit && blk_valid[nxt]) blk_prev[nxt] = blk;
            return r;
        endfunction

        function void note_request(logic action, logic [ffha_pkg::SIZE_W-1:0] req,
                                   logic [ffha_pkg::OFFSET_W-1:0] off);
            if (action == ffha_pkg::ACT_ALLOC) expected_results.push_back(allocate(req));
            else expected_results.push_back(release_block(off));
        endfunction

        task report_mismatch(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(logic [ffha_pkg::OFFSET_W-1:0] off, logic [1:0] st);
            alloc_result_t e;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result offset=%0d status=%0d", off, st));
                return;
            end
            e = expected_results.pop_front();
            if (off !== e.offset)
                report_mismatch($sformatf("offset %0d, predicted %0d", off, e.offset));
            if (st !== e.status)
                report_mismatch($sformatf("status %0d, predicted %0d", st, e.status));
        endtask
    endclass

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          cfg_wen = 1'b0;
    logic [ffha_pkg::CFG_W-1:0]    cfg_wdata = '0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic                          s_action = ffha_pkg::ACT_ALLOC;
    logic [ffha_pkg::SIZE_W-1:0]   s_req_size = '0;
    logic [ffha_pkg::OFFSET_W-1:0] s_free_offset = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [ffha_pkg::OFFSET_W-1:0] m_payload_offset;
    logic [1:0]                    m_status;

    heap_scoreboard sb = new();
    int  tx_idle_pct = 0;
    int  rx_idle_pct = 0;
    bit  hold_req = 0;
    int  hold_left = 0;
    int  quiet_cycles = 0;

    first_fit_heap_allocator u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_action(s_action),
        .s_req_size(s_req_size), .s_free_offset(s_free_offset),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_payload_offset(m_payload_offset), .m_status(m_status)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Result side: check, then choose ready for the next edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_result(m_payload_offset, m_status);
            if (hold_req) begin
                hold_left = HOLD_LEN;
                hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCH_MAX) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task send_request(logic action, int unsigned req, int unsigned off);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= action;
        s_req_size <= ffha_pkg::SIZE_W'(req);
        s_free_offset <= ffha_pkg::OFFSET_W'(off);
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(action, ffha_pkg::SIZE_W'(req), ffha_pkg::OFFSET_W'(off));
    endtask

    task drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task write_limit(int unsigned value);
        drain_results();
        cfg_wen <= 1'b1;
        cfg_wdata <= ffha_pkg::CFG_W'(value);
        @(posedge aclk);
        cfg_wen <= 1'b0;
        sb.set_limit(value);
    endtask

    task random_request();
        int unsigned pick;
        int unsigned lim;
        pick = $urandom_range(99);
        lim = sb.limit;
        if (pick < 45) begin
            if ($urandom_range(9) == 0)
                send_request(ffha_pkg::ACT_ALLOC, $urandom_range(lim - 1, 1), 0);
            else
                send_request(ffha_pkg::ACT_ALLOC,
                             $urandom_range(lim > 16 ? 16 : lim - 1, 1), 0);
        end else if (pick < 50) begin
            send_request(ffha_pkg::ACT_ALLOC, ($urandom_range(1) != 0) ? 0 :
                         $urandom_range(4095, lim > 4095 ? 4095 : lim), 0);
        end else if (pick < 88 && sb.live_offsets.size() != 0) begin
            send_request(ffha_pkg::ACT_FREE, $urandom_range(4095),
                         sb.live_offsets[$urandom_range(sb.live_offsets.size() - 1)]);
        end else if (pick < 92) begin
            send_request(ffha_pkg::ACT_FREE, $urandom_range(4095), 0);
        end else begin
            send_request(ffha_pkg::ACT_FREE, $urandom_range(4095), $urandom_range(4095));
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: size extremes, exact fit, stray and zero-offset frees, first block.
        send_request(ffha_pkg::ACT_ALLOC, 0, 0);
        send_request(ffha_pkg::ACT_ALLOC, 4095, 0);
        send_request(ffha_pkg::ACT_ALLOC, 1, 0);
        send_request(ffha_pkg::ACT_ALLOC, 4095, 0);
        send_request(ffha_pkg::ACT_ALLOC, 100, 0);
        send_request(ffha_pkg::ACT_ALLOC, 50, 0);
        send_request(ffha_pkg::ACT_FREE, 4095, 3);
        send_request(ffha_pkg::ACT_FREE, 0, 3);
        send_request(ffha_pkg::ACT_FREE, 0, 0);
        send_request(ffha_pkg::ACT_FREE, 0, 4095);
        send_request(ffha_pkg::ACT_ALLOC, 99, 0);
        send_request(ffha_pkg::ACT_FREE, 0, 1);
        send_request(ffha_pkg::ACT_FREE, 0, 3);
        send_request(ffha_pkg::ACT_FREE, 0, 105);
        send_request(ffha_pkg::ACT_ALLOC, 4094, 0);
        send_request(ffha_pkg::ACT_FREE, 0, 2);
        write_limit(0);
        send_request(ffha_pkg::ACT_ALLOC, 1, 0);
        send_request(ffha_pkg::ACT_ALLOC, 1, 0);
        send_request(ffha_pkg::ACT_ALLOC, 2, 0);
        send_request(ffha_pkg::ACT_FREE, 0, 2);
        send_request(ffha_pkg::ACT_FREE, 0, 1);

        write_limit(64);
        tx_idle_pct = 38;
        rx_idle_pct = 62;
        for (int i = 0; i < 130; i++) random_request();

        write_limit(8191);
        tx_idle_pct = 62;
        rx_idle_pct = 38;
        for (int i = 0; i < 130; i++) begin
            if (i == 40) hold_req = 1;
            random_request();
        end

        write_limit(200);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        for (int i = 0; i < 140; i++) begin
            // Let every outstanding transaction complete before carrying on.
            if (i == 70) drain_results();
            random_request();
        end

        drain_results();
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

`default_nettype wire
